### sv/almc_pkg.sv
`timescale 1ns / 1ps

package almc_pkg;

  localparam int unsigned CACHE_SLOTS_DEF  = 2;
  localparam int unsigned MATRIX_WORDS_DEF = 16;
  localparam int unsigned QUEUE_DEPTH      = 2;

  localparam int unsigned TAG_W      = 8;
  localparam int unsigned AGE_W      = 8;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned FRAC_W     = 9;
  localparam int unsigned FRAC_SHIFT = 8;
  localparam int unsigned POS_W      = 4;
  localparam int unsigned SLOT_W     = 3;

  localparam logic [TAG_W-1:0] EMPTY_TAG = 8'hFF;
  localparam logic [AGE_W-1:0] AGE_FULL  = 8'hFF;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0]  pos;
    logic              last;
    logic [WORD_W-1:0] start;
    logic [WORD_W-1:0] delta;
  } entry_t;

  typedef struct packed {
    logic full;
    logic avail;
  } queue_stat_t;

endpackage

### sv/almc_ram.sv
`timescale 1ns / 1ps

module almc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### sv/almc_front.sv
`timescale 1ns / 1ps

module almc_front import almc_pkg::*; #(
  parameter int unsigned CACHE_SLOTS  = CACHE_SLOTS_DEF,
  parameter int unsigned MATRIX_WORDS = MATRIX_WORDS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [TAG_W-1:0]         matrix_index_i,
  input  logic signed [WORD_W-1:0] start_word_i,
  input  logic signed [WORD_W-1:0] end_word_i,
  input  queue_stat_t              q_stat_i,
  output logic                     push_o,
  output entry_t                   push_data_o
);

  logic [TAG_W-1:0]  tag_q [CACHE_SLOTS];
  logic [TAG_W-1:0]  tag_d [CACHE_SLOTS];
  logic [AGE_W-1:0]  age_q [CACHE_SLOTS];
  logic [AGE_W-1:0]  age_d [CACHE_SLOTS];
  logic [AGE_W-1:0]  age_half [CACHE_SLOTS];
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [SLOT_W-1:0] cur_slot_q, cur_slot_d;
  logic              cur_hit_q, cur_hit_d;
  logic              accept, first, last;
  logic              lookup_hit;
  logic [SLOT_W-1:0] hit_slot, victim, pick;
  logic [AGE_W-1:0]  min_age;

  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i && !q_stat_i.full;
  assign push_o     = accept;
  assign first      = (pos_q == '0);
  assign last       = (pos_q == POS_W'(MATRIX_WORDS - 1));

  always_comb begin
    lookup_hit = 1'b0;
    hit_slot   = '0;
    victim     = '0;
    for (int i = 0; i < CACHE_SLOTS; i++) begin
      age_half[i] = age_q[i] >> 1;
    end
    min_age = age_half[0];
    for (int i = CACHE_SLOTS - 1; i >= 0; i--) begin
      if (tag_q[i] == matrix_index_i && matrix_index_i != EMPTY_TAG) begin
        lookup_hit = 1'b1;
        hit_slot   = SLOT_W'(i);
      end
    end
    for (int i = 1; i < CACHE_SLOTS; i++) begin
      if (age_half[i] < min_age) begin
        min_age = age_half[i];
        victim  = SLOT_W'(i);
      end
    end
    pick = lookup_hit ? hit_slot : victim;
  end

  always_comb begin
    pos_d      = pos_q;
    cur_slot_d = cur_slot_q;
    cur_hit_d  = cur_hit_q;
    for (int i = 0; i < CACHE_SLOTS; i++) begin
      tag_d[i] = tag_q[i];
      age_d[i] = age_q[i];
    end
    if (accept) begin
      pos_d = last ? '0 : pos_q + POS_W'(1);
      if (first) begin
        cur_slot_d = pick;
        cur_hit_d  = lookup_hit;
        for (int i = 0; i < CACHE_SLOTS; i++) begin
          if (SLOT_W'(i) == pick) begin
            age_d[i] = AGE_FULL;
            if (!lookup_hit) begin
              tag_d[i] = matrix_index_i;
            end
          end else begin
            age_d[i] = age_half[i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      cur_slot_q <= '0;
      cur_hit_q  <= 1'b0;
      for (int i = 0; i < CACHE_SLOTS; i++) begin
        tag_q[i] <= EMPTY_TAG;
        age_q[i] <= '0;
      end
    end else begin
      pos_q      <= pos_d;
      cur_slot_q <= cur_slot_d;
      cur_hit_q  <= cur_hit_d;
      for (int i = 0; i < CACHE_SLOTS; i++) begin
        tag_q[i] <= tag_d[i];
        age_q[i] <= age_d[i];
      end
    end
  end

  always_comb begin
    push_data_o.hit   = first ? lookup_hit : cur_hit_q;
    push_data_o.slot  = first ? pick : cur_slot_q;
    push_data_o.pos   = pos_q;
    push_data_o.last  = last;
    push_data_o.start = start_word_i;
    push_data_o.delta = end_word_i - start_word_i;
  end

endmodule

### sv/almc_queue.sv
`timescale 1ns / 1ps

module almc_queue import almc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  entry_t      push_data_i,
  output queue_stat_t stat_o,
  input  logic        pop_i,
  output entry_t      pop_data_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t           mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign stat_o.full  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign stat_o.avail = (cnt_q != '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && stat_o.avail;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### sv/almc_back.sv
`timescale 1ns / 1ps

module almc_back import almc_pkg::*; #(
  parameter int unsigned CACHE_SLOTS  = CACHE_SLOTS_DEF,
  parameter int unsigned MATRIX_WORDS = MATRIX_WORDS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [FRAC_W-1:0]        blend_fraction_i,
  input  queue_stat_t              q_stat_i,
  input  entry_t                   q_data_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [WORD_W-1:0] matrix_word_o,
  output logic [POS_W-1:0]         word_position_o,
  output logic                     was_hit_o,
  output logic                     slot_used_o,
  output logic                     last_word_o
);

  localparam int unsigned DEPTH  = CACHE_SLOTS * MATRIX_WORDS;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned PROD_W = WORD_W + FRAC_W;

  logic                     adv;
  logic [ADDR_W-1:0]        rd_addr;
  logic signed [PROD_W-1:0] prod;
  logic [WORD_W-1:0]        ram_rdata;
  logic                     ram_we;

  logic                     a_valid_q;
  entry_t                   a_entry_q;
  logic [WORD_W-1:0]        a_scaled_q;
  logic [ADDR_W-1:0]        a_addr_q;
  logic                     a_fwd_q;
  logic [WORD_W-1:0]        fwd_word_q;
  logic [WORD_W-1:0]        a_blend, a_word;

  logic                     out_valid_q;
  logic [WORD_W-1:0]        out_word_q;
  logic [POS_W-1:0]         out_pos_q;
  logic                     out_hit_q, out_slot_q, out_last_q;

  assign adv     = !out_valid_q || !out_stall_i;
  assign pop_o   = adv && q_stat_i.avail;
  assign rd_addr = ADDR_W'(q_data_i.slot) * ADDR_W'(MATRIX_WORDS) + ADDR_W'(q_data_i.pos);
  assign prod    = $signed(q_data_i.delta) * $signed({1'b0, blend_fraction_i});

  assign a_blend = a_entry_q.start + a_scaled_q;
  assign a_word  = !a_entry_q.hit ? a_blend : (a_fwd_q ? fwd_word_q : ram_rdata);
  assign ram_we  = adv && a_valid_q && !a_entry_q.hit;

  almc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(a_addr_q),
    .wdata_i(a_blend),
    .re_i   (pop_o),
    .raddr_i(rd_addr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q   <= q_stat_i.avail;
      out_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      a_entry_q  <= q_data_i;
      a_scaled_q <= prod[WORD_W+FRAC_SHIFT-1:FRAC_SHIFT];
      a_addr_q   <= rd_addr;
      a_fwd_q    <= ram_we && (rd_addr == a_addr_q);
      fwd_word_q <= a_blend;
    end
    if (adv && a_valid_q) begin
      out_word_q <= a_word;
      out_pos_q  <= a_entry_q.pos;
      out_hit_q  <= a_entry_q.hit;
      out_slot_q <= a_entry_q.slot[0];
      out_last_q <= a_entry_q.last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign matrix_word_o   = out_word_q;
  assign word_position_o = out_pos_q;
  assign was_hit_o       = out_hit_q;
  assign slot_used_o     = out_slot_q;
  assign last_word_o     = out_last_q;

endmodule

### sv/aging_lru_matrix_cache.sv
// Path: a word is registered in the queue, then the back-end a stage, then the output register.
// Throughput: one word per cycle when not stalled; the output register gates
//   the back end, and the two-entry queue lets the front end keep taking words while it stalls.
// Reset: tags go to empty, ages and the word counter to zero, blend fraction
//   to zero, queue and pipeline empty; cached words are not cleared.
`timescale 1ns / 1ps

module aging_lru_matrix_cache import almc_pkg::*; #(
  parameter int unsigned CACHE_SLOTS  = CACHE_SLOTS_DEF,
  parameter int unsigned MATRIX_WORDS = MATRIX_WORDS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [FRAC_W-1:0]        cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [TAG_W-1:0]         matrix_index_i,
  input  logic signed [WORD_W-1:0] start_word_i,
  input  logic signed [WORD_W-1:0] end_word_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [WORD_W-1:0] matrix_word_o,
  output logic [POS_W-1:0]         word_position_o,
  output logic                     was_hit_o,
  output logic                     slot_used_o,
  output logic                     last_word_o
);

  logic [FRAC_W-1:0] blend_fraction_q;
  queue_stat_t       q_stat;
  logic              push, pop;
  entry_t            push_data, pop_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blend_fraction_q <= '0;
    end else if (cfg_we_i) begin
      blend_fraction_q <= cfg_wdata_i;
    end
  end

  almc_front #(
    .CACHE_SLOTS (CACHE_SLOTS),
    .MATRIX_WORDS(MATRIX_WORDS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .matrix_index_i(matrix_index_i),
    .start_word_i  (start_word_i),
    .end_word_i    (end_word_i),
    .q_stat_i      (q_stat),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  almc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .stat_o     (q_stat),
    .pop_i      (pop),
    .pop_data_o (pop_data)
  );

  almc_back #(
    .CACHE_SLOTS (CACHE_SLOTS),
    .MATRIX_WORDS(MATRIX_WORDS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .blend_fraction_i(blend_fraction_q),
    .q_stat_i        (q_stat),
    .q_data_i        (pop_data),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .matrix_word_o   (matrix_word_o),
    .word_position_o (word_position_o),
    .was_hit_o       (was_hit_o),
    .slot_used_o     (slot_used_o),
    .last_word_o     (last_word_o)
  );

endmodule

### sv/almc_checker.sv
`timescale 1ns / 1ps

module almc_checker import almc_pkg::*; #(
  parameter int unsigned MATRIX_WORDS = MATRIX_WORDS_DEF
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic signed [WORD_W-1:0] matrix_word_o,
  input logic [POS_W-1:0]         word_position_o,
  input logic                     was_hit_o,
  input logic                     slot_used_o,
  input logic                     last_word_o
);

  logic             out_acc;
  logic             seen_q;
  logic [POS_W-1:0] prev_pos_q;
  logic             prev_last_q, prev_hit_q, prev_slot_q;
  logic [POS_W-1:0] exp_pos;

  assign out_acc = out_valid_o && !out_stall_i;
  assign exp_pos = (!seen_q || prev_last_q) ? '0 : prev_pos_q + POS_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= 1'b0;
      prev_pos_q  <= '0;
      prev_last_q <= 1'b0;
      prev_hit_q  <= 1'b0;
      prev_slot_q <= 1'b0;
    end else if (out_acc) begin
      seen_q      <= 1'b1;
      prev_pos_q  <= word_position_o;
      prev_last_q <= last_word_o;
      prev_hit_q  <= was_hit_o;
      prev_slot_q <= slot_used_o;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped under stall");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(matrix_word_o) && $stable(word_position_o)
      && $stable(was_hit_o) && $stable(slot_used_o) && $stable(last_word_o))
    else $error("output payload changed under stall");

  a_pos_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> word_position_o == exp_pos)
    else $error("word position out of sequence");

  a_req_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && seen_q && word_position_o != '0 |->
      was_hit_o == prev_hit_q && slot_used_o == prev_slot_q)
    else $error("hit or slot changed within a request");

  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> last_word_o == (word_position_o == POS_W'(MATRIX_WORDS - 1)))
    else $error("last word flag does not match position");

endmodule

bind aging_lru_matrix_cache almc_checker #(.MATRIX_WORDS(MATRIX_WORDS)) u_almc_checker (.*);
